[hw/rtl/cpair_pkg.sv]
// cpair_pkg: shared types and constants for the closest point pair block.
// No dependencies; imported by every cpair module.
`default_nettype none

package cpair_pkg;

    localparam int COORD_W        = 16;            // coordinate width
    localparam int DIST_W         = 2*COORD_W + 1; // squared distance of a pair
    localparam int BEST_W         = DIST_W + 1;    // running best, all ones = none yet
    localparam int MAX_POINTS_DEF = 256;
    localparam int QUEUE_DEPTH    = 2;
    localparam int IN_DATA_W      = 2*COORD_W;
    localparam int OUT_FIELDS_W   = 4*COORD_W + DIST_W;
    localparam int OUT_DATA_W     = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_USER_W     = 2;

    // one classified point on its way from front to back
    typedef struct packed {
        logic               last;
        logic               drop;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

endpackage

`default_nettype wire

[hw/rtl/closest_point_pair_top.sv]
// closest_point_pair_top: brute-force closest pair of 2-D points over a stream.
// Depends on cpair_pkg, cpair_front, cpair_queue, cpair_back.
//
// Channel  Dir  Signals                        Content (low bit up)
// -------  ---  -----------------------------  -----------------------------------
// s        in   i_s_tvalid/o_s_tready          tdata: point_x[15:0], point_y[31:16]
//                                              tlast: last_point
// m        out  o_m_tvalid/i_m_tready          tdata: first_x, first_y, second_x,
//                                              second_y, distance_sq (33b), pad
//                                              tuser: found, overflow
//
// A point with points already stored passes these steps in the back end: a pop,
// one stored point read per cycle, three pipe stages (read, difference, square)
// to drain into the compare, then a write of the point into the store.
// The first point of a set skips the scan; a dropped point is only popped. A last
// point then loads the result register, waiting while the previous result waits.
// Reset is synchronous, active low; the point memory needs no clearing.
// A two-entry queue lets the input keep accepting while the back end scans, and
// the result register lets the next set start while a result waits on i_m_tready.
`default_nettype none

module closest_point_pair_top #(
    parameter int MAX_POINTS = cpair_pkg::MAX_POINTS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    input  wire logic [cpair_pkg::IN_DATA_W-1:0]   i_s_tdata,   // point_x, point_y
    input  wire logic                              i_s_tlast,   // last_point
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    output logic [cpair_pkg::OUT_DATA_W-1:0]       o_m_tdata,   // first_x, first_y,
                                                                // second_x, second_y,
                                                                // distance_sq
    output logic [cpair_pkg::OUT_USER_W-1:0]       o_m_tuser    // found, overflow
);
    import cpair_pkg::*;

    t_cmd      push_cmd;
    t_cmd      pop_cmd;
    t_q_status q_status;
    logic      push;
    logic      pop;

    // front: handshake and capacity check
    cpair_front #(
        .MAX_POINTS (MAX_POINTS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .i_q_status (q_status),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    cpair_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (push_cmd),
        .i_pop    (pop),
        .o_cmd    (pop_cmd),
        .o_status (q_status)
    );

    // back: store, compare against every stored point, keep the best pair
    cpair_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (q_status),
        .i_cmd      (pop_cmd),
        .o_pop      (pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

`default_nettype wire

[hw/rtl/cpair_front.sv]
// cpair_front: input side; accepts points and marks those beyond capacity.
// Depends on cpair_pkg.
`default_nettype none

module cpair_front #(
    parameter int MAX_POINTS = cpair_pkg::MAX_POINTS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    input  wire logic [cpair_pkg::IN_DATA_W-1:0] i_s_tdata,
    input  wire logic                           i_s_tlast,
    input  wire cpair_pkg::t_q_status           i_q_status,
    output logic                                o_push,
    output cpair_pkg::t_cmd                     o_cmd
);
    import cpair_pkg::*;

    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    logic [CNT_W-1:0] r_cnt;
    logic             accept;

    assign o_s_tready = !i_q_status.full;
    assign accept     = i_s_tvalid && o_s_tready;
    assign o_push     = accept;

    assign o_cmd.x    = i_s_tdata[COORD_W-1:0];
    assign o_cmd.y    = i_s_tdata[2*COORD_W-1:COORD_W];
    assign o_cmd.last = i_s_tlast;
    assign o_cmd.drop = (r_cnt == CNT_W'(MAX_POINTS));

    // mirrors the back end's fill count so the drop decision is made here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (accept) begin
            if (i_s_tlast) begin
                r_cnt <= '0;
            end else if (!o_cmd.drop) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/cpair_queue.sv]
// cpair_queue: short FIFO of classified points between front and back.
// Depends on cpair_pkg.
`default_nettype none

module cpair_queue (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire cpair_pkg::t_cmd      i_cmd,
    input  wire logic                 i_pop,
    output cpair_pkg::t_cmd           o_cmd,
    output cpair_pkg::t_q_status      o_status
);
    import cpair_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FIL_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [FIL_W-1:0] r_fill;

    assign o_status.empty = (r_fill == '0);
    assign o_status.full  = (r_fill == FIL_W'(QUEUE_DEPTH));
    assign o_cmd          = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (!i_push && i_pop) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/cpair_back.sv]
// cpair_back: point store, distance pipeline, running best pair, result register.
// Depends on cpair_pkg.
`default_nettype none

module cpair_back #(
    parameter int MAX_POINTS = cpair_pkg::MAX_POINTS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire cpair_pkg::t_q_status             i_q_status,
    input  wire cpair_pkg::t_cmd                  i_cmd,
    output logic                                  o_pop,
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    output logic [cpair_pkg::OUT_DATA_W-1:0]      o_m_tdata,
    output logic [cpair_pkg::OUT_USER_W-1:0]      o_m_tuser
);
    import cpair_pkg::*;

    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int SQ_W  = 2*COORD_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [COORD_W-1:0] mem_x [MAX_POINTS];
    logic [COORD_W-1:0] mem_y [MAX_POINTS];

    logic [1:0]         r_state;
    logic [CNT_W-1:0]   r_cnt;
    logic [IDX_W-1:0]   r_idx;
    t_cmd               r_cur;
    logic               r_dropped;
    logic [BEST_W-1:0]  r_best_d;
    logic [COORD_W-1:0] r_bfx, r_bfy, r_bsx, r_bsy;

    // stage 1: stored point read
    logic               r_v1;
    logic [COORD_W-1:0] r_mx, r_my;
    // stage 2: absolute differences
    logic               r_v2;
    logic [COORD_W-1:0] r_ax, r_ay, r_px2, r_py2;
    // stage 3: squares
    logic               r_v3;
    logic [SQ_W-1:0]    r_sqx, r_sqy;
    logic [COORD_W-1:0] r_px3, r_py3;

    logic               r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [OUT_USER_W-1:0] r_out_user;

    logic rd_en, wr_en, pipe_empty, out_free, load_out, take, found;
    logic signed [COORD_W:0] dx, dy;
    logic [BEST_W-1:0]  d_sum;

    assign pipe_empty = !r_v1 && !r_v2 && !r_v3;
    assign out_free   = !r_out_valid || i_m_tready;
    assign rd_en      = (r_state == ST_SCAN);
    assign wr_en      = (r_state == ST_DRAIN) && pipe_empty;
    assign load_out   = (r_state == ST_EMIT) && out_free;
    assign o_pop      = (r_state == ST_IDLE) && !i_q_status.empty;
    assign found      = (r_cnt >= CNT_W'(2));

    assign dx    = $signed({r_mx[COORD_W-1], r_mx}) - $signed({r_cur.x[COORD_W-1], r_cur.x});
    assign dy    = $signed({r_my[COORD_W-1], r_my}) - $signed({r_cur.y[COORD_W-1], r_cur.y});
    assign d_sum = BEST_W'(r_sqx) + BEST_W'(r_sqy);
    // the second point of a set always takes the first pair
    assign take  = r_v3 && ((r_cnt == CNT_W'(1)) || (d_sum < r_best_d));

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_mx <= mem_x[r_idx];
            r_my <= mem_y[r_idx];
        end
        if (wr_en) begin
            mem_x[r_cnt[IDX_W-1:0]] <= r_cur.x;
            mem_y[r_cnt[IDX_W-1:0]] <= r_cur.y;
        end
    end

    // datapath stages, no reset
    always_ff @(posedge i_clk) begin
        r_ax  <= dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
        r_ay  <= dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
        r_px2 <= r_mx;
        r_py2 <= r_my;
        r_sqx <= SQ_W'(r_ax) * SQ_W'(r_ax);
        r_sqy <= SQ_W'(r_ay) * SQ_W'(r_ay);
        r_px3 <= r_px2;
        r_py3 <= r_py2;
        if (o_pop) begin
            r_cur <= i_cmd;
        end
        if (take) begin
            r_bfx <= r_px3;
            r_bfy <= r_py3;
            r_bsx <= r_cur.x;
            r_bsy <= r_cur.y;
        end
        if (load_out) begin
            r_out_data <= found ? {{(OUT_DATA_W-OUT_FIELDS_W){1'b0}},
                                   r_best_d[DIST_W-1:0], r_bsy, r_bsx, r_bfy, r_bfx}
                                : '0;
            r_out_user <= {r_dropped, found};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_idx       <= '0;
            r_dropped   <= 1'b0;
            r_best_d    <= '1;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_v1 <= rd_en;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (take) begin
                r_best_d <= d_sum;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        if (i_cmd.drop) begin
                            r_dropped <= 1'b1;
                            r_state   <= i_cmd.last ? ST_EMIT : ST_IDLE;
                        end else if (r_cnt == '0) begin
                            r_state <= ST_DRAIN;
                        end else begin
                            r_idx   <= '0;
                            r_state <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == IDX_W'(r_cnt - 1'b1)) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (pipe_empty) begin
                        r_cnt   <= r_cnt + 1'b1;
                        r_state <= r_cur.last ? ST_EMIT : ST_IDLE;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        r_cnt     <= '0;
                        r_dropped <= 1'b0;
                        r_best_d  <= '1;
                        r_state   <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

`ifndef SYNTH
    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_cnt != '0) && (CNT_W'(r_idx) < r_cnt))
        else $error("scan index outside stored points");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |-> (r_cnt <= CNT_W'(MAX_POINTS)))
        else $error("point count above capacity");
    a_emit_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> pipe_empty)
        else $error("result taken with comparisons in flight");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !i_q_status.empty)
        else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

[bench/closest_point_pair_top_test.sv]
// closest_point_pair_top_test: self-checking bench for closest_point_pair_top.
// Streams point sets and predicts each closest-pair word in a scoreboard.
// Depends on cpair_pkg and closest_point_pair_top.
`default_nettype none

module closest_point_pair_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cpair_pkg::*;

    localparam int CAPACITY   = MAX_POINTS_DEF;
    localparam int QUIET_MAX  = 4000;   // cycles with no handshake before giving up
    localparam int DRAIN_WAIT = 300;    // > scan time of a full store
    localparam int ITEM_GOAL  = 1500;
    localparam int BIG_SET_A  = 12;     // set index filled to exactly capacity
    localparam int BIG_SET_B  = 40;     // set index that overruns capacity
    localparam longint unsigned NO_BEST = (64'd1 << BEST_W) - 64'd1;

    typedef logic signed [COORD_W-1:0] coord_t;

    // one word on the result stream, unpacked
    typedef struct packed {
        coord_t            first_x;
        coord_t            first_y;
        coord_t            second_x;
        coord_t            second_y;
        logic [DIST_W-1:0] dist_sq;
        logic              found;
        logic              overflow;
    } pair_result_t;

    // directed stimulus row; want is used only when typed is set
    typedef struct {
        coord_t       x;
        coord_t       y;
        logic         last;
        logic         typed;
        pair_result_t want;
    } point_row_t;

    localparam coord_t CMIN = 16'sh8000;
    localparam coord_t CMAX = 16'sh7FFF;

    // lone point: nothing to pair with, everything zero
    localparam pair_result_t LONE_SET = '0;
    // opposite corners of the coordinate range: the largest distance there is
    localparam pair_result_t CORNER_PAIR = '{
        first_x: CMIN, first_y: CMIN, second_x: CMAX, second_y: CMAX,
        dist_sq: 33'd8589672450, found: 1'b1, overflow: 1'b0};
    // two coincident points
    localparam pair_result_t TWIN_PAIR = '{
        first_x: 16'sd5, first_y: 16'sd5, second_x: 16'sd5, second_y: 16'sd5,
        dist_sq: '0, found: 1'b1, overflow: 1'b0};

    localparam int DIR_ROWS = 15;
    point_row_t dir_rows [DIR_ROWS] = '{
        '{16'sh1234, -16'sd5,    1'b1, 1'b1, LONE_SET},    // single point right after reset
        '{CMIN,      CMIN,       1'b0, 1'b0, '0},
        '{CMAX,      CMAX,       1'b1, 1'b1, CORNER_PAIR},
        '{16'sd5,    16'sd5,     1'b0, 1'b0, '0},
        '{16'sd5,    16'sd5,     1'b1, 1'b1, TWIN_PAIR},
        '{16'sd0,    16'sd0,     1'b0, 1'b0, '0},          // equal distances: earliest wins
        '{16'sd1,    16'sd0,     1'b0, 1'b0, '0},
        '{16'sd2,    16'sd0,     1'b1, 1'b0, '0},
        '{-16'sd1,   -16'sd1,    1'b0, 1'b0, '0},          // all bits set
        '{CMAX,      CMIN,       1'b0, 1'b0, '0},
        '{CMIN,      CMAX,       1'b0, 1'b0, '0},
        '{16'sd100,  -16'sd200,  1'b0, 1'b0, '0},
        '{-16'sd100, 16'sd200,   1'b0, 1'b0, '0},
        '{-16'sd1,   16'sd0,     1'b1, 1'b0, '0},
        '{16'sd0,    -16'sd1,    1'b1, 1'b1, LONE_SET}
    };

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata  = '0;     // point_x, point_y
    logic                  i_s_tlast  = 1'b0;   // last_point
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;           // first_x, first_y, second_x, second_y,
                                                // distance_sq, pad
    logic [OUT_USER_W-1:0] o_m_tuser;           // found, overflow

    closest_point_pair_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Closest-pair tracker: own copy of the point store and running best
    // ---------------------------------------------------------------
    coord_t          held_x [CAPACITY];
    coord_t          held_y [CAPACITY];
    int unsigned     held_count = 0;
    longint unsigned best_sq    = NO_BEST;
    int unsigned     best_a     = 0;
    int unsigned     best_b     = 0;
    logic            lost_point = 1'b0;

    pair_result_t pending_pairs [$];   // closest-pair words still owed by the block

    int unsigned idle_pct     = 31;    // percent of cycles each side holds off
    int unsigned points_sent  = 0;
    int unsigned sets_sent    = 0;
    int unsigned pairs_seen   = 0;
    int unsigned overruns     = 0;
    int unsigned errors       = 0;
    int unsigned quiet_cycles = 0;

    // Fold one point into the tracker; on the last point of a set return its word.
    function automatic void track_point(input coord_t x, input coord_t y, input logic last,
                                        output logic emitted, output pair_result_t res);
        longint          dx;
        longint          dy;
        longint unsigned d;
        emitted = 1'b0;
        res     = '0;
        if (held_count < CAPACITY) begin
            // later point fixed, scan earlier points in arrival order
            for (int i = 0; i < held_count; i++) begin
                dx = longint'(held_x[i]) - longint'(x);
                dy = longint'(held_y[i]) - longint'(y);
                d  = longint'(dx * dx + dy * dy);
                if (held_count == 1 || d < best_sq) begin
                    best_sq = d;
                    best_a  = i;
                    best_b  = held_count;
                end
            end
            held_x[held_count] = x;
            held_y[held_count] = y;
            held_count++;
        end else begin
            lost_point = 1'b1;   // store full: point neither kept nor compared
        end
        if (last) begin
            emitted = 1'b1;
            if (held_count >= 2) begin
                res.first_x  = held_x[best_a];
                res.first_y  = held_y[best_a];
                res.second_x = held_x[best_b];
                res.second_y = held_y[best_b];
                res.dist_sq  = best_sq[DIST_W-1:0];
                res.found    = 1'b1;
            end
            res.overflow = lost_point;
            held_count   = 0;
            best_sq      = NO_BEST;
            best_a       = 0;
            best_b       = 0;
            lost_point   = 1'b0;
        end
    endfunction

    // Offer one point word and hold it until accepted, then log the expectation.
    // Each cycle before the offer idles with probability idle_pct.
    task automatic send_point(input coord_t x, input coord_t y, input logic last,
                              input logic typed, input pair_result_t want);
        logic         emitted;
        pair_result_t res;
        if ($urandom_range(99) < idle_pct) begin
            i_s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {y, x};
        i_s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
        track_point(x, y, last, emitted, res);
        if (emitted) begin
            pending_pairs.push_back(typed ? want : res);
            sets_sent++;
        end
        points_sent++;
    endtask

    // Random coordinate; the flavor picks wide spread, a tight grid that
    // forces ties and duplicates, or points hugging the range corners.
    function automatic coord_t pick_coord(input int unsigned flavor);
        int v;
        case (flavor)
            0: begin
                v = int'($urandom_range(16'hFFFF)) - 32768;
            end
            1: begin
                v = int'($urandom_range(8)) - 4;
            end
            default: begin
                v = $urandom_range(1) ? 32767 - int'($urandom_range(3))
                                      : -32768 + int'($urandom_range(3));
            end
        endcase
        return coord_t'(v);
    endfunction

    // ---------------------------------------------------------------
    // Result side: random back-pressure and scoreboard
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= idle_pct);
    end

    task automatic check_field(input string what, input logic signed [63:0] want_v,
                               input logic signed [63:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want_v, got_v);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        pair_result_t got;
        pair_result_t want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.first_x  = o_m_tdata[0*COORD_W +: COORD_W];
            got.first_y  = o_m_tdata[1*COORD_W +: COORD_W];
            got.second_x = o_m_tdata[2*COORD_W +: COORD_W];
            got.second_y = o_m_tdata[3*COORD_W +: COORD_W];
            got.dist_sq  = o_m_tdata[4*COORD_W +: DIST_W];
            got.found    = o_m_tuser[0];
            got.overflow = o_m_tuser[1];
            pairs_seen++;
            if (got.overflow === 1'b1) overruns++;
            if (pending_pairs.size() == 0) begin
                $display("%0t: unexpected result word, expected none, actual %h/%b",
                         $time, o_m_tdata, o_m_tuser);
                errors++;
            end else begin
                want = pending_pairs.pop_front();
                check_field("first_x",     want.first_x,  got.first_x);
                check_field("first_y",     want.first_y,  got.first_y);
                check_field("second_x",    want.second_x, got.second_x);
                check_field("second_y",    want.second_y, got.second_y);
                check_field("distance_sq", want.dist_sq,  got.dist_sq);
                check_field("found",       want.found,    got.found);
                check_field("overflow",    want.overflow, got.overflow);
            end
        end
    end

    // Watchdog: any handshake on either side counts as progress.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_MAX) begin
            $display("%0t: no handshake for %0d cycles, %0d words still owed",
                     $time, QUIET_MAX, pending_pairs.size());
            $display("closest_point_pair_top_test: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    initial begin
        int unsigned set_no;
        int unsigned set_len;
        int unsigned flavor;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: lone points, corner pair, duplicates, ties, sign extremes
        for (int r = 0; r < DIR_ROWS; r++) begin
            send_point(dir_rows[r].x, dir_rows[r].y, dir_rows[r].last,
                       dir_rows[r].typed, dir_rows[r].want);
        end

        // random sets: mostly short, one filling the store exactly and one
        // running past it so that the last point itself is dropped
        set_no = 0;
        while (points_sent < ITEM_GOAL) begin
            if (set_no == BIG_SET_A)      set_len = CAPACITY;
            else if (set_no == BIG_SET_B) set_len = CAPACITY + 2;
            else                          set_len = $urandom_range(1, 12);
            flavor   = (set_len > 12) ? 0 : $urandom_range(2);
            // a stretch of sets with neither side holding off
            idle_pct = (set_no >= 60 && set_no < 90) ? 0 : 31;
            for (int p = 0; p < set_len; p++) begin
                send_point(pick_coord(flavor), pick_coord(flavor),
                           p == set_len - 1, 1'b0, '0);
            end
            set_no++;
        end
        i_s_tvalid <= 1'b0;

        while (pending_pairs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("%0d points in %0d sets sent, %0d closest-pair words checked,",
                 points_sent, sets_sent, pairs_seen);
        $display("%0d of them with dropped points, %0d mismatches", overruns, errors);
        if (errors == 0 && pending_pairs.size() == 0) begin
            $display("closest_point_pair_top_test: clean");
        end else begin
            $display("closest_point_pair_top_test: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
hw/rtl/cpair_pkg.sv
hw/rtl/cpair_front.sv
hw/rtl/cpair_queue.sv
hw/rtl/cpair_back.sv
hw/rtl/closest_point_pair_top.sv
bench/closest_point_pair_top_test.sv
